@@ sv/assert_macros.svh @@
// Assertion macros shared by the RLS filter RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define RLS_ASSERT_NOW(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rls_pkg.sv @@
// Package for the RLS adaptive FIR: payload structs, sequencer states,
// register codes and divider request/response types. No dependencies.
`timescale 1ns / 1ps

package rls_pkg;

    localparam int WORD_W    = 32;
    localparam int DIV_MAG_W = 48;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_RES_W = DIV_Q_W + 2;

    localparam logic [1:0] REG_FORGET = 2'd0;
    localparam logic [1:0] REG_DELTA  = 2'd1;
    localparam logic [1:0] REG_TAPS   = 2'd2;

    localparam logic [16:0] LAMBDA_RESET = 17'd64881;
    localparam logic [16:0] LAMBDA_MAX   = 17'd65536;
    localparam logic [30:0] DELTA_RESET  = 31'd655;
    localparam logic [5:0]  TAPS_RESET   = 6'd32;

    typedef struct packed {
        logic               func;
        logic signed [31:0] sample_in;
        logic signed [31:0] desired;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] filter_out;
        logic signed [31:0] error_out;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLR_DIV,
        ST_CLR,
        ST_IDLE,
        ST_SHIFT,
        ST_SHIFT0,
        ST_PI,
        ST_GAMMA,
        ST_GAIN,
        ST_YOUT,
        ST_EOUT,
        ST_WUPD,
        ST_PUPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIV_MAG_W-1:0] mag;
        logic [31:0]          dvs;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [DIV_RES_W-1:0] res;
    } div_rsp_t;

endpackage

@@ sv/rls_ram.sv @@
// Simple dual-port word memory: one write port, one registered read port.
// Uses rls_pkg for the word width.
`timescale 1ns / 1ps

module rls_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [rls_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [rls_pkg::WORD_W-1:0] rdata
);

    logic [rls_pkg::WORD_W-1:0] mem [DEPTH];
    logic [rls_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rls_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, truncating toward zero.
// Reports an overflowed quotient as all-ones magnitude. Uses rls_pkg types.
`timescale 1ns / 1ps

module rls_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  rls_pkg::div_req_t req,
    output rls_pkg::div_rsp_t rsp
);

    localparam int QW = rls_pkg::DIV_Q_W;
    localparam int MW = rls_pkg::DIV_MAG_W;
    localparam int RW = rls_pkg::DIV_RES_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          ovf_reg, ovf_next;
    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0]   dvs_reg, dvs_next;

    logic [QW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_mag;
    logic signed [RW-1:0] q_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        trial = {rem_reg[QW-2:0], quo_reg[QW-1]};
        ge    = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            // high part must stay below the divisor, else quotient exceeds QW bits
            busy_next = 1'b1;
            cnt_next  = 6'(QW);
            neg_next  = req.neg;
            ovf_next  = 32'(req.mag[MW-1:QW]) >= req.dvs;
            rem_next  = QW'(req.mag[MW-1:QW]);
            quo_next  = req.mag[QW-1:0];
            dvs_next  = req.dvs;
        end else if (busy_reg) begin
            rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign q_mag = ovf_reg ? '1 : quo_reg;
    assign q_pos = RW'(q_mag);

    always_comb begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.res  = neg_reg ? -q_pos : q_pos;
    end

endmodule

@@ sv/rls_adaptive_fir.sv @@
// RLS adaptive FIR, Q16.16, one shared MAC and one radix-2 divider around word memories.
// For N taps in use, a sample runs N*N divides on the divider for the P update;
// a clear item gives no result.
// One item in flight; the result sits in an output register while the next item runs.
// Reset (aresetn low, synchronous) restores registers, then a sweep loads
// P = I/delta and zeroes delay line and weights; no item is taken meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rls_adaptive_fir #(
    parameter int TAPS       = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rls_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rls_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WB    = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int IW    = $clog2(TAPS);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int PA_W  = $clog2(TAPS * TAPS);
    localparam int ACC_W = 56;
    localparam int SW    = 57;
    localparam int MW    = rls_pkg::DIV_MAG_W;
    localparam logic signed [SW-1:0] WMAX = SW'((64'sd1 <<< (WB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);

    function automatic logic [32:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        logic                 f;
        r = v;
        f = 1'b0;
        if (v > WMAX) begin
            r = WMAX;
            f = 1'b1;
        end else if (v < WMIN) begin
            r = WMIN;
            f = 1'b1;
        end
        return {f, r[31:0]};
    endfunction

    function automatic logic [MW-1:0] mag_q16(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w < 0) begin
            w = -w;
        end
        return {w[31:0], 16'b0};
    endfunction

    // configuration
    logic [16:0] lam_cfg_reg;
    logic [30:0] delta_cfg_reg;
    logic [5:0]  taps_cfg_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lam_cfg_reg   <= rls_pkg::LAMBDA_RESET;
            delta_cfg_reg <= rls_pkg::DELTA_RESET;
            taps_cfg_reg  <= rls_pkg::TAPS_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                rls_pkg::REG_FORGET: lam_cfg_reg   <= pwdata[16:0];
                rls_pkg::REG_DELTA:  delta_cfg_reg <= pwdata[30:0];
                rls_pkg::REG_TAPS:   taps_cfg_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rls_pkg::REG_FORGET: prdata = {15'b0, lam_cfg_reg};
            rls_pkg::REG_DELTA:  prdata = {1'b0, delta_cfg_reg};
            rls_pkg::REG_TAPS:   prdata = {26'b0, taps_cfg_reg};
            default:             prdata = '0;
        endcase
    end

    logic [CW-1:0] n_eff;
    logic [16:0]   lam_eff;
    logic [30:0]   delta_eff;

    assign n_eff = (taps_cfg_reg == 6'd0) ? CW'(1) :
                   (32'(taps_cfg_reg) > TAPS) ? CW'(TAPS) : CW'(taps_cfg_reg);
    assign lam_eff = (lam_cfg_reg == 17'd0) ? 17'd1 :
                     (lam_cfg_reg > rls_pkg::LAMBDA_MAX) ? rls_pkg::LAMBDA_MAX : lam_cfg_reg;
    assign delta_eff = (delta_cfg_reg == 31'd0) ? 31'd1 : delta_cfg_reg;

    // sequencer registers
    rls_pkg::state_t state_reg, state_next;
    logic [1:0]          sub_reg, sub_next;
    logic [CW-1:0]       i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [16:0]         lam_reg, lam_next;
    logic signed [31:0]  x_reg, x_next, d_reg, d_next;
    logic signed [31:0]  y_reg, y_next, e_reg, e_next;
    logic [31:0]         gamma_reg, gamma_next, diag_reg, diag_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic                flag_reg, flag_next;
    logic                m_valid_reg, m_valid_next;
    rls_pkg::out_item_t  m_data_reg, m_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rls_pkg::ST_CLR_DIV;
            sub_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sub_reg     <= sub_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg      <= n_next;
        lam_reg    <= lam_next;
        x_reg      <= x_next;
        d_reg      <= d_next;
        y_reg      <= y_next;
        e_reg      <= e_next;
        gamma_reg  <= gamma_next;
        diag_reg   <= diag_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        flag_reg   <= flag_next;
        m_data_reg <= m_data_next;
    end

    // memories
    logic [IW-1:0]   i_ix, j_ix, im1_ix;
    logic [CW-1:0]   im1;
    logic [PA_W-1:0] p_addr;
    logic            p_we, dl_we, w_we, pi_we, k_we;
    logic [31:0]     p_wdata, dl_wdata, w_wdata, pi_wdata, k_wdata;
    logic [IW-1:0]   dl_waddr, dl_raddr, w_waddr, pi_raddr;
    logic [31:0]     p_rdata, dl_rdata, w_rdata, pi_rdata, k_rdata;

    assign im1      = i_reg - CW'(1);
    assign i_ix     = i_reg[IW-1:0];
    assign j_ix     = j_reg[IW-1:0];
    assign im1_ix   = im1[IW-1:0];
    assign p_addr   = PA_W'(PA_W'(i_ix) * PA_W'(TAPS)) + PA_W'(j_ix);
    assign dl_raddr = (state_reg == rls_pkg::ST_SHIFT) ? im1_ix :
                      (state_reg == rls_pkg::ST_PI) ? j_ix : i_ix;
    assign pi_raddr = (state_reg == rls_pkg::ST_PUPD) ? j_ix : i_ix;
    assign w_waddr  = (state_reg == rls_pkg::ST_CLR) ? j_ix : i_ix;
    assign dl_waddr = (state_reg == rls_pkg::ST_CLR) ? j_ix :
                      (state_reg == rls_pkg::ST_SHIFT0) ? '0 : i_ix;

    rls_ram #(.DEPTH(TAPS * TAPS), .AW(PA_W)) u_p_ram (
        .aclk(aclk), .we(p_we), .waddr(p_addr), .wdata(p_wdata),
        .raddr(p_addr), .rdata(p_rdata)
    );
    rls_ram #(.DEPTH(TAPS), .AW(IW)) u_dl_ram (
        .aclk(aclk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_rdata)
    );
    rls_ram #(.DEPTH(TAPS), .AW(IW)) u_w_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(i_ix), .rdata(w_rdata)
    );
    rls_ram #(.DEPTH(TAPS), .AW(IW)) u_pi_ram (
        .aclk(aclk), .we(pi_we), .waddr(i_ix), .wdata(pi_wdata),
        .raddr(pi_raddr), .rdata(pi_rdata)
    );
    rls_ram #(.DEPTH(TAPS), .AW(IW)) u_k_ram (
        .aclk(aclk), .we(k_we), .waddr(i_ix), .wdata(k_wdata),
        .raddr(i_ix), .rdata(k_rdata)
    );

    // divider
    rls_pkg::div_req_t div_req;
    rls_pkg::div_rsp_t div_rsp;

    rls_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    // MAC datapath
    logic signed [31:0]  p_rd, dl_rd, w_rd, pi_rd, k_rd;
    logic signed [31:0]  op_a, op_b;
    logic signed [63:0]  rnd_full;
    logic signed [47:0]  rnd48;
    logic signed [ACC_W-1:0] acc_add;
    logic [32:0] sat_acc, sat_wsum, sat_diff, sat_div, sat_err, sat_x, sat_d;

    assign p_rd  = $signed(p_rdata);
    assign dl_rd = $signed(dl_rdata);
    assign w_rd  = $signed(w_rdata);
    assign pi_rd = $signed(pi_rdata);
    assign k_rd  = $signed(k_rdata);

    always_comb begin
        case (state_reg)
            rls_pkg::ST_PI: begin
                op_a = p_rd;
                op_b = dl_rd;
            end
            rls_pkg::ST_GAMMA: begin
                op_a = dl_rd;
                op_b = pi_rd;
            end
            rls_pkg::ST_YOUT: begin
                op_a = w_rd;
                op_b = dl_rd;
            end
            rls_pkg::ST_WUPD: begin
                op_a = k_rd;
                op_b = e_reg;
            end
            default: begin
                op_a = k_rd;
                op_b = pi_rd;
            end
        endcase
    end

    assign rnd_full = (prod_reg + 64'sd32768) >>> 16;
    assign rnd48    = rnd_full[47:0];
    assign acc_add  = acc_reg + ACC_W'(rnd48);
    assign sat_acc  = sat_w(SW'(acc_add));
    assign sat_wsum = sat_w(SW'(w_rd) + SW'(rnd48));
    assign sat_diff = sat_w(SW'(p_rd) - SW'(rnd48));
    assign sat_div  = sat_w(SW'(div_rsp.res));
    assign sat_err  = sat_w(SW'(d_reg) - SW'(y_reg));
    assign sat_x    = sat_w(SW'(s_data.sample_in));
    assign sat_d    = sat_w(SW'(s_data.desired));

    logic last_i, last_j;
    assign last_i = (i_reg == n_reg - CW'(1));
    assign last_j = (j_reg == n_reg - CW'(1));

    always_comb begin
        state_next   = state_reg;
        sub_next     = sub_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        lam_next     = lam_reg;
        x_next       = x_reg;
        d_next       = d_reg;
        y_next       = y_reg;
        e_next       = e_reg;
        gamma_next   = gamma_reg;
        diag_next    = diag_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        flag_next    = flag_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        p_we         = 1'b0;
        dl_we        = 1'b0;
        w_we         = 1'b0;
        pi_we        = 1'b0;
        k_we         = 1'b0;
        p_wdata      = sat_div[31:0];
        dl_wdata     = dl_rdata;
        w_wdata      = sat_wsum[31:0];
        pi_wdata     = sat_acc[31:0];
        k_wdata      = sat_div[31:0];
        div_req      = '0;

        unique case (state_reg)
            rls_pkg::ST_CLR_DIV: begin
                if (sub_reg == 2'd0) begin
                    div_req.start = 1'b1;
                    div_req.mag   = MW'(64'h1_0000_0000);
                    div_req.dvs   = {1'b0, delta_eff};
                    sub_next      = 2'd1;
                end else if (div_rsp.done) begin
                    diag_next  = sat_div[31:0];
                    i_next     = '0;
                    j_next     = '0;
                    sub_next   = 2'd0;
                    state_next = rls_pkg::ST_CLR;
                end
            end
            rls_pkg::ST_CLR: begin
                p_we     = 1'b1;
                p_wdata  = (i_reg == j_reg) ? diag_reg : '0;
                dl_we    = (i_reg == '0);
                dl_wdata = '0;
                w_we     = (i_reg == '0);
                w_wdata  = '0;
                if (j_reg == CW'(TAPS - 1)) begin
                    j_next = '0;
                    if (i_reg == CW'(TAPS - 1)) begin
                        state_next = rls_pkg::ST_IDLE;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            rls_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sub_next = 2'd0;
                    if (s_data.func) begin
                        state_next = rls_pkg::ST_CLR_DIV;
                    end else begin
                        x_next     = sat_x[31:0];
                        d_next     = sat_d[31:0];
                        flag_next  = sat_x[32] | sat_d[32];
                        n_next     = n_eff;
                        lam_next   = lam_eff;
                        i_next     = n_eff - CW'(1);
                        state_next = (n_eff > CW'(1)) ? rls_pkg::ST_SHIFT
                                                      : rls_pkg::ST_SHIFT0;
                    end
                end
            end
            rls_pkg::ST_SHIFT: begin
                // read entry i-1, then move it up to i
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else begin
                    dl_we    = 1'b1;
                    sub_next = 2'd0;
                    if (i_reg == CW'(1)) begin
                        state_next = rls_pkg::ST_SHIFT0;
                    end else begin
                        i_next = i_reg - CW'(1);
                    end
                end
            end
            rls_pkg::ST_SHIFT0: begin
                dl_we      = 1'b1;
                dl_wdata   = x_reg;
                i_next     = '0;
                j_next     = '0;
                acc_next   = '0;
                sub_next   = 2'd0;
                state_next = rls_pkg::ST_PI;
            end
            rls_pkg::ST_PI: begin
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else if (sub_reg == 2'd1) begin
                    prod_next = op_a * op_b;
                    sub_next  = 2'd2;
                end else begin
                    acc_next = acc_add;
                    sub_next = 2'd0;
                    if (last_j) begin
                        pi_we     = 1'b1;
                        flag_next = flag_reg | sat_acc[32];
                        j_next    = '0;
                        acc_next  = '0;
                        if (last_i) begin
                            i_next     = '0;
                            acc_next   = ACC_W'(lam_reg);
                            state_next = rls_pkg::ST_GAMMA;
                        end else begin
                            i_next = i_reg + CW'(1);
                        end
                    end else begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end
            rls_pkg::ST_GAMMA, rls_pkg::ST_YOUT: begin
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else if (sub_reg == 2'd1) begin
                    prod_next = op_a * op_b;
                    sub_next  = 2'd2;
                end else begin
                    acc_next = acc_add;
                    sub_next = 2'd0;
                    if (last_i) begin
                        flag_next = flag_reg | sat_acc[32];
                        i_next    = '0;
                        if (state_reg == rls_pkg::ST_GAMMA) begin
                            // floor gamma at one LSB
                            gamma_next = ($signed(sat_acc[31:0]) < 32'sd1) ? 32'd1
                                                                          : sat_acc[31:0];
                            state_next = rls_pkg::ST_GAIN;
                        end else begin
                            y_next     = sat_acc[31:0];
                            state_next = rls_pkg::ST_EOUT;
                        end
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            rls_pkg::ST_GAIN: begin
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else if (sub_reg == 2'd1) begin
                    div_req.start = 1'b1;
                    div_req.neg   = pi_rd[31];
                    div_req.mag   = mag_q16(pi_rd);
                    div_req.dvs   = gamma_reg;
                    sub_next      = 2'd2;
                end else if (div_rsp.done) begin
                    k_we      = 1'b1;
                    flag_next = flag_reg | sat_div[32];
                    sub_next  = 2'd0;
                    if (last_i) begin
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = rls_pkg::ST_YOUT;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            rls_pkg::ST_EOUT: begin
                e_next     = sat_err[31:0];
                flag_next  = flag_reg | sat_err[32];
                i_next     = '0;
                sub_next   = 2'd0;
                state_next = rls_pkg::ST_WUPD;
            end
            rls_pkg::ST_WUPD: begin
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else if (sub_reg == 2'd1) begin
                    prod_next = op_a * op_b;
                    sub_next  = 2'd2;
                end else begin
                    w_we      = 1'b1;
                    flag_next = flag_reg | sat_wsum[32];
                    sub_next  = 2'd0;
                    if (last_i) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = rls_pkg::ST_PUPD;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end
            end
            rls_pkg::ST_PUPD: begin
                if (sub_reg == 2'd0) begin
                    sub_next = 2'd1;
                end else if (sub_reg == 2'd1) begin
                    prod_next = op_a * op_b;
                    sub_next  = 2'd2;
                end else if (sub_reg == 2'd2) begin
                    div_req.start = 1'b1;
                    div_req.neg   = sat_diff[31];
                    div_req.mag   = mag_q16($signed(sat_diff[31:0]));
                    div_req.dvs   = {15'b0, lam_reg};
                    flag_next     = flag_reg | sat_diff[32];
                    sub_next      = 2'd3;
                end else if (div_rsp.done) begin
                    p_we      = 1'b1;
                    flag_next = flag_reg | sat_div[32];
                    sub_next  = 2'd0;
                    if (last_j) begin
                        j_next = '0;
                        if (last_i) begin
                            state_next = rls_pkg::ST_DONE;
                        end else begin
                            i_next = i_reg + CW'(1);
                        end
                    end else begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end
            rls_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.filter_out = y_reg;
                    m_data_next.error_out  = e_reg;
                    m_data_next.saturated  = flag_reg;
                    m_valid_next           = 1'b1;
                    state_next             = rls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rls_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RLS_ASSERT_NOW(a_ready_quiet, aclk, aresetn, !s_ready || (!div_rsp.busy && !p_we), "input ready while divider or P write active")
    `RLS_ASSERT_NOW(a_div_start_free, aclk, aresetn, !div_req.start || !div_rsp.busy, "divider started while busy")
    `RLS_ASSERT_NEXT(a_done_result, aclk, aresetn, (state_reg == rls_pkg::ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg, "finished sample did not raise a result")

endmodule

@@ verif/tb_rls_adaptive_fir.sv @@
// Testbench for rls_adaptive_fir: directed table then randomized phases, results
// scored against a Q16.16 RLS predictor or typed table rows. Depends on rls_pkg and the RTL.
`timescale 1ns / 1ps

module tb_rls_adaptive_fir;

    localparam int    NT      = 32;
    localparam longint W_MAX  = 64'sd2147483647;
    localparam longint W_MIN  = -64'sd2147483648;
    localparam int    SETTLE  = 1200;   // covers a clear sweep
    localparam int    N_RAND  = 270;
    localparam logic [3:0] A_FORGET = 4'(rls_pkg::REG_FORGET) << 2;
    localparam logic [3:0] A_DELTA  = 4'(rls_pkg::REG_DELTA) << 2;
    localparam logic [3:0] A_TAPS   = 4'(rls_pkg::REG_TAPS) << 2;
    localparam logic [3:0] A_UNUSED = 4'd12;
    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_CLEAR  = 1'b1;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rls_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rls_pkg::out_item_t m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    rls_adaptive_fir u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // filter state mirror
    logic [16:0] lam_reg;
    logic [30:0] delta_reg;
    logic [5:0]  taps_reg;
    longint      taps_line [NT];
    longint      coef [NT];
    longint      pmat [NT*NT];
    longint      pi_v [NT];
    longint      gain_v [NT];
    bit          sat_seen;

    typedef struct {
        bit                 typed;
        rls_pkg::out_item_t want;
    } pinned_t;

    rls_pkg::out_item_t expected_q [$];
    pinned_t   pinned_q [$];
    int        errors = 0;
    bit        calm = 1'b0;
    int        hold_req = 0;
    int        hold_len = 0;

    function automatic longint sat_w(longint v);
        if (v > W_MAX) begin
            sat_seen = 1'b1;
            return W_MAX;
        end
        if (v < W_MIN) begin
            sat_seen = 1'b1;
            return W_MIN;
        end
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic void clear_learning();
        longint dv;
        longint diag;
        dv = (delta_reg == 0) ? 64'sd1 : longint'(delta_reg);
        diag = sat_w(64'sd4294967296 / dv);
        for (int i = 0; i < NT; i++) begin
            taps_line[i] = 0;
            coef[i] = 0;
            pi_v[i] = 0;
            gain_v[i] = 0;
        end
        for (int i = 0; i < NT*NT; i++) pmat[i] = 0;
        for (int i = 0; i < NT; i++) pmat[i*NT+i] = diag;
    endfunction

    // advance the mirror by one item; returns 1 when a result is due
    function automatic bit rls_update(rls_pkg::in_item_t it, output rls_pkg::out_item_t r);
        int     n;
        longint lam, acc, gam, y, e, diff;
        r = '0;
        sat_seen = 1'b0;
        if (it.func == FN_CLEAR) begin
            clear_learning();
            return 1'b0;
        end
        n   = (taps_reg == 0) ? 1 : (taps_reg > NT) ? NT : int'(taps_reg);
        lam = (lam_reg == 0) ? 64'sd1 :
              (lam_reg > rls_pkg::LAMBDA_MAX) ? 64'sd65536 : longint'(lam_reg);
        for (int i = n - 1; i > 0; i--) taps_line[i] = taps_line[i-1];
        taps_line[0] = sat_w(longint'(it.sample_in));
        for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += qmul(pmat[i*NT+j], taps_line[j]);
            pi_v[i] = sat_w(acc);
        end
        acc = lam;
        for (int i = 0; i < n; i++) acc += qmul(taps_line[i], pi_v[i]);
        gam = sat_w(acc);
        if (gam < 1) gam = 1;
        for (int i = 0; i < n; i++) gain_v[i] = sat_w((pi_v[i] * 64'sd65536) / gam);
        acc = 0;
        for (int i = 0; i < n; i++) acc += qmul(coef[i], taps_line[i]);
        y = sat_w(acc);
        e = sat_w(sat_w(longint'(it.desired)) - y);
        for (int i = 0; i < n; i++) coef[i] = sat_w(coef[i] + qmul(gain_v[i], e));
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                diff = sat_w(pmat[i*NT+j] - qmul(gain_v[i], pi_v[j]));
                pmat[i*NT+j] = sat_w((diff * 64'sd65536) / lam);
            end
        end
        r.filter_out = y[31:0];
        r.error_out  = e[31:0];
        r.saturated  = sat_seen;
        return 1'b1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: %s got %h want %h", $time, what, got, want);
    endtask

    // input transfers feed the predictor
    always @(posedge aclk) begin
        rls_pkg::out_item_t r;
        pinned_t   p;
        if (aresetn && s_valid && s_ready) begin
            if (rls_update(s_data, r)) begin
                if (pinned_q.size() > 0) begin
                    p = pinned_q.pop_front();
                    if (p.typed) r = p.want;
                end
                expected_q.push_back(r);
            end
        end
    end

    // result transfers are scored
    always @(posedge aclk) begin
        rls_pkg::out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", m_data.filter_out, '0);
            end else begin
                w = expected_q.pop_front();
                if (m_data.filter_out !== w.filter_out)
                    report("filter_out", m_data.filter_out, w.filter_out);
                if (m_data.error_out !== w.error_out)
                    report("error_out", m_data.error_out, w.error_out);
                if (m_data.saturated !== w.saturated)
                    report("saturated", 32'(m_data.saturated), 32'(w.saturated));
            end
        end
    end

    // receiver: random stalls, calm stretches, and requested long hold-offs
    initial begin
        int seen_req;
        int left;
        seen_req = 0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                left = hold_len;
            end
            if (left > 0) begin
                left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
            end
        end
    end

    task automatic send(rls_pkg::in_item_t it);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait out every result, then the longest no-result sweep
    task automatic wait_idle();
        while (expected_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic reg_write(logic [3:0] addr, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (addr)
            A_FORGET: lam_reg   = val[16:0];
            A_DELTA:  delta_reg = val[30:0];
            A_TAPS:   taps_reg  = val[5:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return 32'($signed($urandom_range(524288)) - 262144);
        endcase
    endfunction

    typedef struct {
        bit                 is_cfg;
        logic [3:0]         addr;
        logic [31:0]        wdata;
        rls_pkg::in_item_t  it;
        bit                 typed;
        rls_pkg::out_item_t want;
    } row_t;

    function automatic row_t cfg_row(logic [3:0] a, logic [31:0] v);
        row_t r;
        r = '{1'b1, a, v, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic row_t smp_row(logic [31:0] x, logic [31:0] d, bit typed,
                                     logic [31:0] y, logic [31:0] e);
        row_t r;
        r = '{1'b0, '0, '0, '{FN_SAMPLE, x, d}, typed, '{y, e, 1'b0}};
        return r;
    endfunction

    function automatic row_t clr_row();
        row_t r;
        r = '{1'b0, '0, '0, '{FN_CLEAR, 32'h1234_5678, 32'hfedc_ba98}, 1'b0, '0};
        return r;
    endfunction

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        row_t              tbl [$];
        rls_pkg::in_item_t it;
        int                sent;
        int                phase;
        int                cnt;

        lam_reg = rls_pkg::LAMBDA_RESET;
        delta_reg = rls_pkg::DELTA_RESET;
        taps_reg = rls_pkg::TAPS_RESET;
        clear_learning();

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // zero samples on a cleared filter: y stays 0, e passes d through
        tbl.push_back(smp_row(32'h0, 32'h7fff_ffff, 1, 32'h0, 32'h7fff_ffff));
        tbl.push_back(cfg_row(A_TAPS, 32'h2));
        tbl.push_back(smp_row(32'h0, 32'h8000_0000, 1, 32'h0, 32'h8000_0000));
        tbl.push_back(smp_row(32'h0, 32'h0, 1, 32'h0, 32'h0));
        tbl.push_back(smp_row(32'h0001_0000, 32'h0002_0000, 0, '0, '0));
        tbl.push_back(smp_row(32'hffff_0000, 32'hffff_8000, 0, '0, '0));
        tbl.push_back(smp_row(32'h7fff_ffff, 32'h8000_0000, 0, '0, '0));
        tbl.push_back(smp_row(32'h8000_0000, 32'h7fff_ffff, 0, '0, '0));
        tbl.push_back(smp_row(32'h0000_0001, 32'hffff_ffff, 0, '0, '0));
        tbl.push_back(clr_row());
        tbl.push_back(smp_row(32'h0, 32'h0000_3039, 1, 32'h0, 32'h0000_3039));
        // taps of zero acts as one tap, above the maximum as all taps
        tbl.push_back(cfg_row(A_TAPS, 32'hffff_ffc0));
        tbl.push_back(smp_row(32'h0003_0000, 32'h0001_0000, 0, '0, '0));
        tbl.push_back(cfg_row(A_TAPS, 32'h3f));
        tbl.push_back(smp_row(32'h0000_8000, 32'h0001_0000, 0, '0, '0));
        // lambda extremes: zero, full scale, above full scale (one LSB comes after the delta rows)
        tbl.push_back(cfg_row(A_TAPS, 32'h3));
        tbl.push_back(cfg_row(A_FORGET, 32'h0));
        tbl.push_back(smp_row(32'h0002_0000, 32'h0005_0000, 0, '0, '0));
        tbl.push_back(smp_row(32'hfffe_0000, 32'h0000_0000, 0, '0, '0));
        tbl.push_back(cfg_row(A_FORGET, 32'h0001_0000));
        tbl.push_back(smp_row(32'h0001_0000, 32'hffff_0000, 0, '0, '0));
        tbl.push_back(cfg_row(A_FORGET, 32'hffff_ffff));
        tbl.push_back(smp_row(32'h0004_0000, 32'h0001_0000, 0, '0, '0));
        // delta of zero and delta at full scale only show up after a clear
        tbl.push_back(cfg_row(A_DELTA, 32'h8000_0000));
        tbl.push_back(clr_row());
        tbl.push_back(smp_row(32'h0000_4000, 32'h0000_c000, 0, '0, '0));
        tbl.push_back(cfg_row(A_DELTA, 32'h7fff_ffff));
        tbl.push_back(cfg_row(A_UNUSED, 32'hdead_beef));
        tbl.push_back(clr_row());
        tbl.push_back(smp_row(32'h0001_0000, 32'h0001_0000, 0, '0, '0));
        tbl.push_back(cfg_row(A_FORGET, 32'h1));
        tbl.push_back(smp_row(32'hfff0_0000, 32'h0010_0000, 0, '0, '0));

        foreach (tbl[i]) begin
            if (tbl[i].is_cfg) begin
                drop_valid();
                wait_idle();
                reg_write(tbl[i].addr, tbl[i].wdata);
            end else begin
                if (tbl[i].it.func == FN_SAMPLE)
                    pinned_q.push_back('{tbl[i].typed, tbl[i].want});
                send(tbl[i].it);
            end
        end

        // randomized phases on small tap counts
        sent = 0;
        phase = 0;
        while (sent < N_RAND) begin
            drop_valid();
            wait_idle();
            if (phase == 0 || $urandom_range(1)) begin
                reg_write(A_TAPS, ($urandom & 32'hffff_ffc0) | $urandom_range(6));
            end
            if (phase == 0 || $urandom_range(1)) begin
                case ($urandom_range(5))
                    0: reg_write(A_FORGET, 32'h0);
                    1: reg_write(A_FORGET, 32'h1_ffff);
                    2: reg_write(A_FORGET, 32'h1_0000);
                    default: reg_write(A_FORGET, $urandom_range(65536, 58000));
                endcase
            end
            if ($urandom_range(2) == 0) begin
                reg_write(A_DELTA, $urandom_range(3) == 0 ? $urandom
                                                          : $urandom_range(70000));
                send('{FN_CLEAR, $urandom, $urandom});
            end
            calm = (phase == 2);
            cnt = $urandom_range(40, 20);
            for (int k = 0; k < cnt; k++) begin
                if (phase == 4 && k == 3) begin
                    hold_len = 4000;
                    hold_req++;
                end
                if (phase == 6 && k == cnt / 2) begin
                    drop_valid();
                    while (expected_q.size() > 0) @(posedge aclk);
                end
                if ($urandom_range(19) == 0) begin
                    it = '{FN_CLEAR, $urandom, $urandom};
                end else begin
                    it = '{FN_SAMPLE, rand_word(), rand_word()};
                end
                send(it);
                sent++;
            end
            phase++;
        end
        calm = 1'b0;
        drop_valid();

        while (expected_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
